>>> sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; included by the checker module of the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked property with a reset guard
`define PRWH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// a stalled transfer keeps valid high and the payload unchanged
`define PRWH_ASSERT_HOLD(label, clk, rst_n, vld, stl, data, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> (vld && $stable(data))) else $error(msg);

`endif

>>> sv/prwh_pkg.sv
// shared types, constants and arithmetic helpers for the prewitt edge block
// no dependencies; used by the top level, the checker and the testbench
package prwh_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned PIX_W         = 24;
  localparam int unsigned CFG_W_BITS    = 11;
  localparam int unsigned CFG_H_BITS    = 13;
  localparam int unsigned ROW_BITS      = 12;
  localparam int unsigned OUT_COL_BITS  = 10;

  // register reset values and register select codes (paddr bit 2)
  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd480;
  localparam logic                  REG_WIDTH    = 1'b0;
  localparam logic                  REG_HEIGHT   = 1'b1;

  // divide by three through a reciprocal, exact for values below 2047
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;
  localparam logic [7:0] EDGE_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] center_row;
    logic [9:0]  center_column;
    logic [7:0]  blue_edge;
    logic [7:0]  green_edge;
    logic [7:0]  red_edge;
  } edge_out_t;

  // magnitude of a signed gradient (range -765..765)
  function automatic logic [9:0] grad_abs(input logic signed [10:0] g);
    logic signed [10:0] n;
    begin
      n = -g;
      grad_abs = g[10] ? n[9:0] : g[9:0];
    end
  endfunction

  // truncating divide by three with clamp to 255
  function automatic logic [7:0] div3_clamp(input logic [9:0] v);
    logic [19:0] p;
    logic [8:0]  q;
    begin
      p = 20'(v) * 20'(DIV3_RECIP);
      q = p[DIV3_SHIFT +: 9];
      div3_clamp = (q > 9'(EDGE_MAX)) ? EDGE_MAX : q[7:0];
    end
  endfunction

endpackage

>>> sv/prewitt_horizontal_edge_rgb_top.sv
// Horizontal Prewitt edge detector for a raster-order RGB pixel stream.
// Input channel: in_valid_i / in_stall_o with one pixel (red, green, blue)
// per transfer, rows of image_width pixels, frames of image_height rows.
// Output channel: out_valid_o / out_stall_i, one result per interior pixel:
// |sum of right minus left column over three rows| / 3 for each color,
// with the column and row of that pixel. Border positions give no result.
// Throughput: one pixel per clock while in_stall_o is low. The pixel that
// completes a 3x3 window passes the read stage (the registered read of the
// line store rams), then the gradient stage, then the output register, whose
// result shows up on out_valid_o.
// Config: APB registers image_width at 0x0 and image_height at 0x4 (pready
// is always high), written by the user only while the block is idle, unenforced.
// Reset clears the counters, the window columns and all valid flags; the
// line stores are not cleared and need no sweep, so the first pixel can be
// taken in the first cycle after reset.
// When the receiver stalls, the output register holds; the gradient stage
// and the read stage behind it keep filling, and in_stall_o rises only
// once the read stage cannot move on.
module prewitt_horizontal_edge_rgb_top #(
  parameter int unsigned MAX_WIDTH = prwh_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prwh_pkg::pix_in_t   in_data_i,
  // edge output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output prwh_pkg::edge_out_t out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import prwh_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > CFG_W_BITS) ? CW + 1 : CFG_W_BITS;

  // configuration registers
  logic [CFG_W_BITS-1:0] width_q;
  logic [CFG_H_BITS-1:0] height_q;
  logic                  cfg_wr;

  // position counters
  logic [CW-1:0]         col_q, col_d;
  logic [ROW_BITS-1:0]   row_q, row_d;

  // read stage
  logic                  s1_valid_q;
  logic                  s1_emit_q;
  logic [CW-1:0]         s1_addr_q;
  logic [PIX_W-1:0]      s1_cur_q;
  logic [OUT_COL_BITS-1:0] s1_col_q;
  logic [ROW_BITS-1:0]   s1_row_q;

  // gradient stage
  logic                  s2_valid_q;
  logic signed [10:0]    s2_grad_q [3];
  logic [OUT_COL_BITS-1:0] s2_col_q;
  logic [ROW_BITS-1:0]   s2_row_q;

  // output register
  logic                  out_valid_q;
  edge_out_t             out_data_q;

  // window columns: 0..2 column c-1, 3..5 column c-2
  logic [PIX_W-1:0]      win_q [6];

  logic [PIX_W-1:0]      up_rd, mid_rd;
  logic                  in_xfer;
  logic                  out_free, s2_free, s1_move, s1_free;
  logic [WW-1:0]         w_eff, col_ext, col_m1;
  logic [CFG_H_BITS-1:0] h_eff, row_ext, row_m1;
  logic                  emit;
  logic signed [10:0]    grad [3];

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_q  <= pwdata[CFG_W_BITS-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_H_BITS-1:0];
        default:    width_q  <= width_q;
      endcase
    end
  end

  // frame size in use, saturated to the supported range
  always_comb begin
    if (width_q < CFG_W_BITS'(3)) begin
      w_eff = WW'(3);
    end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q < CFG_H_BITS'(3)) begin
      h_eff = CFG_H_BITS'(3);
    end else if (height_q > CFG_H_BITS'(MAX_HEIGHT)) begin
      h_eff = CFG_H_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_move    = s1_valid_q && (!s1_emit_q || s2_free);
  assign s1_free    = !s1_valid_q || s1_move;
  assign in_stall_o = !s1_free;
  assign in_xfer    = in_valid_i && s1_free;

  // position bookkeeping and border test
  assign col_ext = WW'(col_q);
  assign row_ext = CFG_H_BITS'(row_q);
  assign col_m1  = col_ext - WW'(1);
  assign row_m1  = row_ext - CFG_H_BITS'(1);
  assign emit    = (row_ext >= CFG_H_BITS'(2)) && (col_ext >= WW'(2))
                && (col_ext < w_eff) && (row_ext < h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_ext >= w_eff - WW'(1)) begin
      col_d = '0;
      row_d = (row_ext >= h_eff - CFG_H_BITS'(1)) ? '0 : row_q + ROW_BITS'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores: read at the pixel's column, written back when the read stage moves
  prwh_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk_i     (clk_i),
    .wr_en_i   (s1_move),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (mid_rd),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_q),
    .rd_data_o (up_rd)
  );

  prwh_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_middle (
    .clk_i     (clk_i),
    .wr_en_i   (s1_move),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (s1_cur_q),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_q),
    .rd_data_o (mid_rd)
  );

  // read stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_emit_q <= emit;
      s1_addr_q <= col_q;
      s1_cur_q  <= in_data_i;
      s1_col_q  <= col_m1[OUT_COL_BITS-1:0];
      s1_row_q  <= row_m1[ROW_BITS-1:0];
    end
  end

  // per-channel right column minus left column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      grad[k] = $signed({1'b0, 10'(up_rd[8*k +: 8]) + 10'(mid_rd[8*k +: 8])
                               + 10'(s1_cur_q[8*k +: 8])})
              - $signed({1'b0, 10'(win_q[3][8*k +: 8]) + 10'(win_q[4][8*k +: 8])
                               + 10'(win_q[5][8*k +: 8])});
    end
  end

  // window columns shift by one column per pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_move) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= up_rd;
      win_q[1] <= mid_rd;
      win_q[2] <= s1_cur_q;
    end
  end

  // gradient stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_move && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_move && s1_emit_q) begin
      s2_grad_q <= grad;
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
    end
  end

  // output register: magnitude divided by three
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_valid_q) begin
      out_data_q.red_edge      <= div3_clamp(grad_abs(s2_grad_q[0]));
      out_data_q.green_edge    <= div3_clamp(grad_abs(s2_grad_q[1]));
      out_data_q.blue_edge     <= div3_clamp(grad_abs(s2_grad_q[2]));
      out_data_q.center_column <= s2_col_q;
      out_data_q.center_row    <= s2_row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/prwh_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies; used by the top level for the two line stores
module prwh_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/prwh_checker.sv
// port-level checks for the prewitt edge block, bound to its top level
// depends on prwh_pkg and the macros in assert_macros.svh
`include "assert_macros.svh"

module prwh_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input prwh_pkg::pix_in_t   in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input prwh_pkg::edge_out_t out_data_o,
  input logic                pready
);

  import prwh_pkg::*;

  // a stalled result stays on the port unchanged
  `PRWH_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_data_o, "output changed while stalled")

  // results only ever belong to interior pixels
  `PRWH_ASSERT(a_interior, clk_i, rst_ni, out_valid_o |-> (out_data_o.center_column != 10'd0 && out_data_o.center_row != 12'd0), "result for a border pixel")

  // nothing comes out in the first cycle after reset
  `PRWH_ASSERT(a_reset_quiet, clk_i, rst_ni, $rose(rst_ni) |-> !out_valid_o, "result right after reset")

  // a result needs an earlier pixel transfer
  `PRWH_ASSERT(a_no_early_out, clk_i, rst_ni, ($rose(out_valid_o) && $past(rst_ni, 2) && $past(!out_valid_o, 2)) |-> ($past(in_valid_i && !in_stall_o, 2) || $past(in_valid_i && !in_stall_o, 3) || $past(out_valid_o, 3) || $past(rst_ni, 3) != 1'b0), "result without a pixel")

  // the config port never waits
  `PRWH_ASSERT(a_pready, clk_i, rst_ni, pready && (in_data_i == in_data_i), "pready dropped")

endmodule

bind prewitt_horizontal_edge_rgb_top prwh_checker u_prwh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

>>> tb/prewitt_horizontal_edge_rgb_top_tb.sv
// self-checking testbench for the horizontal prewitt edge block on an rgb pixel stream
// depends on prwh_pkg for the payload types and register codes, and on the top level

module prewitt_horizontal_edge_rgb_top_tb;
  import prwh_pkg::*;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_H         = 4096;
  localparam int unsigned RANDOM_PIXELS = 600;
  localparam int unsigned IDLE_GAP      = 8;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  typedef enum {MIX_UNIFORM, MIX_EXTREME, MIX_FLAT, MIX_SMOOTH} pixel_mix_e;
  typedef enum {STALL_NONE, STALL_SPARSE, STALL_BURSTY, STALL_TOGGLE} stall_mode_e;

  // one directed row: pixel, whether the expectation is typed in, and that expectation
  typedef struct packed {
    pix_in_t   pix;
    bit        typed;
    bit        hit;
    edge_out_t want;
  } stim_row_t;

  // three 3x3 frames: strong negative, mixed per color, then free values
  localparam stim_row_t DIR_TABLE [27] = '{
    '{24'hFFFFFF, 1'b1, 1'b0, '0}, '{24'h808080, 1'b1, 1'b0, '0},
    '{24'h000000, 1'b1, 1'b0, '0},
    '{24'hFFFFFF, 1'b1, 1'b0, '0}, '{24'h808080, 1'b1, 1'b0, '0},
    '{24'h000000, 1'b1, 1'b0, '0},
    '{24'hFFFFFF, 1'b1, 1'b0, '0}, '{24'h808080, 1'b1, 1'b0, '0},
    '{24'h000000, 1'b1, 1'b1, '{12'd1, 10'd1, 8'd255, 8'd255, 8'd255}},
    '{24'h07FF00, 1'b1, 1'b0, '0}, '{24'h404040, 1'b1, 1'b0, '0},
    '{24'h0A00FF, 1'b1, 1'b0, '0},
    '{24'h07FF00, 1'b1, 1'b0, '0}, '{24'h404040, 1'b1, 1'b0, '0},
    '{24'h0A00FF, 1'b1, 1'b0, '0},
    '{24'h07FF00, 1'b1, 1'b0, '0}, '{24'h404040, 1'b1, 1'b0, '0},
    '{24'h0A00FF, 1'b1, 1'b1, '{12'd1, 10'd1, 8'd3, 8'd255, 8'd255}},
    '{24'h123456, 1'b0, 1'b0, '0}, '{24'hA5F00F, 1'b0, 1'b0, '0},
    '{24'h3C7E81, 1'b0, 1'b0, '0},
    '{24'hFE0102, 1'b0, 1'b0, '0}, '{24'h7F8000, 1'b0, 1'b0, '0},
    '{24'h55AA33, 1'b0, 1'b0, '0},
    '{24'hC0FFEE, 1'b0, 1'b0, '0}, '{24'h010203, 1'b0, 1'b0, '0},
    '{24'h9A0B77, 1'b0, 1'b0, '0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  pix_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  edge_out_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [23:0] upper_line  [MAX_W];
  logic [23:0] middle_line [MAX_W];
  logic [23:0] win_col [6];
  logic [9:0]  col_cnt;
  logic [11:0] row_cnt;
  logic [10:0] width_reg;
  logic [12:0] height_reg;

  edge_out_t   edge_expect_q [$];
  logic [23:0] prev_pix     = '0;
  int          burst_left   = 0;
  int          mismatches   = 0;
  int          pix_sent     = 0;
  int          edges_seen   = 0;
  int          reg_writes   = 0;
  int          cycle_cnt    = 0;
  stall_mode_e stall_mode   = STALL_NONE;
  int          stall_seg    = 0;
  int          stall_hold   = 0;

  prewitt_horizontal_edge_rgb_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern, switching to a random mode at the end of each random-length segment
  always @(posedge clk_i) begin
    if (stall_seg == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_seg  = $urandom_range(50, 300);
    end else begin
      stall_seg--;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_SPARSE: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      STALL_BURSTY: begin
        if (stall_hold != 0) begin
          stall_hold--;
          out_stall_i <= 1'b1;
        end else begin
          if ($urandom_range(0, 7) == 0) stall_hold = $urandom_range(1, 16);
          out_stall_i <= 1'b0;
        end
      end
      default: begin
        out_stall_i <= ~out_stall_i;
      end
    endcase
  end

  task automatic check_field(input string name, input logic [11:0] want,
                             input logic [11:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare each output transfer with the oldest expected edge result
  always @(posedge clk_i) begin
    edge_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (edge_expect_q.size() == 0) begin
        $error("edge result with nothing expected: row %0d column %0d",
               out_data_o.center_row, out_data_o.center_column);
        mismatches++;
      end else begin
        want = edge_expect_q.pop_front();
        edges_seen++;
        check_field("red_edge", want.red_edge, out_data_o.red_edge);
        check_field("green_edge", want.green_edge, out_data_o.green_edge);
        check_field("blue_edge", want.blue_edge, out_data_o.blue_edge);
        check_field("center_column", want.center_column, out_data_o.center_column);
        check_field("center_row", want.center_row, out_data_o.center_row);
      end
    end
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < 3) h = 3;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  // gradient, line store and counter update for one accepted pixel
  function automatic bit predict_edge(input pix_in_t px, output edge_out_t res);
    int unsigned w, h, col, row, idx;
    logic [23:0] cur, up, mid;
    int          right_sum, left_sum, mag;
    logic [7:0]  edge_ch [3];
    bit          hit;
    w   = eff_width();
    h   = eff_height();
    col = col_cnt;
    row = row_cnt;
    cur = px;
    idx = (col < MAX_W) ? col : MAX_W - 1;
    up  = upper_line[idx];
    mid = middle_line[idx];
    hit = (row >= 2) && (col >= 2) && (col < w) && (row < h);
    res = '0;
    if (hit) begin
      for (int k = 0; k < 3; k++) begin
        right_sum = up[8*k +: 8] + mid[8*k +: 8] + cur[8*k +: 8];
        left_sum  = win_col[3][8*k +: 8] + win_col[4][8*k +: 8] + win_col[5][8*k +: 8];
        mag = right_sum - left_sum;
        if (mag < 0) mag = -mag;
        mag = mag / 3;
        if (mag > 255) mag = 255;
        edge_ch[k] = 8'(mag);
      end
      res.red_edge      = edge_ch[0];
      res.green_edge    = edge_ch[1];
      res.blue_edge     = edge_ch[2];
      res.center_column = 10'(col - 1);
      res.center_row    = 12'(row - 1);
    end
    upper_line[idx]  = mid;
    middle_line[idx] = cur;
    win_col[3] = win_col[0];
    win_col[4] = win_col[1];
    win_col[5] = win_col[2];
    win_col[0] = up;
    win_col[1] = mid;
    win_col[2] = cur;
    // raster position of the next pixel
    if (col >= w - 1) begin
      col_cnt = '0;
      row_cnt = (row >= h - 1) ? 12'd0 : 12'(row + 1);
    end else begin
      col_cnt = 10'(col + 1);
    end
    return hit;
  endfunction

  function automatic pix_in_t gen_pixel(input pixel_mix_e mix);
    case (mix)
      MIX_UNIFORM: begin
        prev_pix = 24'($urandom);
      end
      MIX_EXTREME: begin
        for (int k = 0; k < 3; k++) prev_pix[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      MIX_FLAT: begin
        if ($urandom_range(0, 15) == 0) prev_pix = 24'($urandom);
      end
      default: begin
        for (int k = 0; k < 3; k++)
          prev_pix[8*k +: 8] = prev_pix[8*k +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
      end
    endcase
    return pix_in_t'(prev_pix);
  endfunction

  // apb write: setup phase, access phase until pready, then idle with psel low
  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val[10:0];
    else height_reg = val[12:0];
    reg_writes++;
    @(posedge clk_i);
  endtask

  // one pixel transfer, with sender bursts and gaps
  task automatic send_pixel(input pix_in_t px, input bit use_typed, input bit typed_hit,
                            input edge_out_t typed_res);
    edge_out_t res;
    bit        hit;
    int        gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(100, 300);
      end else begin
        burst_left = $urandom_range(1, 40);
        gap = $urandom_range(1, 6);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    pix_sent++;
    hit = predict_edge(px, res);
    if (use_typed) begin
      hit = typed_hit;
      res = typed_res;
    end
    if (hit) edge_expect_q.push_back(res);
  endtask

  task automatic pause_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (edge_expect_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  // stream pixels until the raster position is back at the frame start
  task automatic to_frame_start(input pixel_mix_e mix);
    while (!(col_cnt == 0 && row_cnt == 0)) send_pixel(gen_pixel(mix), 1'b0, 1'b0, '0);
    pause_input();
    wait_idle();
  endtask

  // whole frames at one setting, written at a frame boundary
  task automatic run_frames(input logic [31:0] w_val, input logic [31:0] h_val,
                            input int frames, input pixel_mix_e mix);
    int unsigned total;
    reg_write(REG_WIDTH, w_val);
    reg_write(REG_HEIGHT, h_val);
    total = eff_width() * eff_height() * frames;
    repeat (total) send_pixel(gen_pixel(mix), 1'b0, 1'b0, '0);
    pause_input();
    wait_idle();
  endtask

  initial begin
    logic [31:0] w_val, h_val;
    int          sel, rand_start;
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    foreach (win_col[i]) win_col[i] = '0;
    col_cnt    = '0;
    row_cnt    = '0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at the smallest size
    reg_write(REG_WIDTH, 32'd3);
    reg_write(REG_HEIGHT, 32'd3);
    foreach (DIR_TABLE[i])
      send_pixel(DIR_TABLE[i].pix, DIR_TABLE[i].typed, DIR_TABLE[i].hit, DIR_TABLE[i].want);
    pause_input();
    wait_idle();

    // width shrinks mid-frame below the current column
    reg_write(REG_WIDTH, 32'd8);
    reg_write(REG_HEIGHT, 32'd4);
    repeat (20) send_pixel(gen_pixel(MIX_UNIFORM), 1'b0, 1'b0, '0);
    pause_input();
    wait_idle();
    reg_write(REG_WIDTH, 32'd3);
    to_frame_start(MIX_UNIFORM);

    // saturated height, then cut mid-frame below the current row
    reg_write(REG_WIDTH, 32'd4);
    reg_write(REG_HEIGHT, 32'd8191);
    repeat (24) send_pixel(gen_pixel(MIX_EXTREME), 1'b0, 1'b0, '0);
    pause_input();
    wait_idle();
    reg_write(REG_HEIGHT, 32'd5);
    to_frame_start(MIX_EXTREME);

    // saturated width: one full row at the widest setting, then narrow the rest
    reg_write(REG_WIDTH, 32'd2047);
    reg_write(REG_HEIGHT, 32'd3);
    repeat (MAX_W + 2) send_pixel(gen_pixel(MIX_UNIFORM), 1'b0, 1'b0, '0);
    pause_input();
    wait_idle();
    reg_write(REG_WIDTH, 32'd3);
    to_frame_start(MIX_UNIFORM);
    run_frames(32'd0, 32'd0, 1, MIX_EXTREME);

    // random settings, mostly small frames
    rand_start = pix_sent;
    while (pix_sent < rand_start + RANDOM_PIXELS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) w_val = $urandom_range(0, 2);
      else if (sel == 1) w_val = $urandom_range(13, 40);
      else w_val = $urandom_range(3, 12);
      h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      run_frames(w_val, h_val, $urandom_range(1, 3), pixel_mix_e'($urandom_range(0, 3)));
    end

    pause_input();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("streamed %0d pixels across %0d register writes, saturated and mid-frame sizes",
             pix_sent, reg_writes);
    $display("compared %0d edge results, %0d mismatches", edges_seen, mismatches);
    if (mismatches == 0 && edge_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
